FILE: rtl/tmr_pkg.sv
package tmr_pkg;

   // sizes
   localparam int unsigned NUM_CHANNELS = 4;
   localparam int unsigned COUNT_W      = 16;
   localparam int unsigned PRESC_W      = 10;
   localparam int unsigned IRQ_W        = 4;
   localparam int unsigned DMA_W        = 2;
   localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

   // request function codes
   localparam logic [1:0] FUNC_TICK   = 2'd0;
   localparam logic [1:0] FUNC_CTRL   = 2'd1;
   localparam logic [1:0] FUNC_RELOAD = 2'd2;

   // prescaler select codes
   localparam logic [1:0] PRESC_DIV1    = 2'd0;
   localparam logic [1:0] PRESC_DIV64   = 2'd1;
   localparam logic [1:0] PRESC_DIV256  = 2'd2;
   localparam logic [1:0] PRESC_DIV1024 = 2'd3;

   typedef struct packed {
      logic [1:0]         func;
      logic [1:0]         timer_id;
      logic               start_req;
      logic               int_enable;
      logic               cascade;
      logic [1:0]         prescale_sel;
      logic [COUNT_W-1:0] reload_value;
   } tmr_req_type;

   typedef struct packed {
      logic [IRQ_W-1:0]   irq_pulse;
      logic [DMA_W-1:0]   dma_request;
      logic [COUNT_W-1:0] counter_value;
   } tmr_rsp_type;

   // command broadcast to every cell
   typedef struct packed {
      logic               tick;
      logic               ctl_wr;
      logic               rld_wr;
      logic               start;
      logic               irq_en;
      logic               cascade;
      logic [1:0]         prescale_sel;
      logic [COUNT_W-1:0] reload_value;
   } tmr_cmd_type;

   // what a cell reports back
   typedef struct packed {
      logic               overflow;
      logic               irq;
      logic [COUNT_W-1:0] count;
   } tmr_stat_type;

   // terminal prescale count for a divider select
   function automatic logic [PRESC_W-1:0] presc_limit(input logic [1:0] sel);
      logic [PRESC_W-1:0] lim;
      unique case (sel)
         PRESC_DIV1:    lim = PRESC_W'(0);
         PRESC_DIV64:   lim = PRESC_W'(63);
         PRESC_DIV256:  lim = PRESC_W'(255);
         PRESC_DIV1024: lim = PRESC_W'(1023);
         default:       lim = PRESC_W'(0);
      endcase
      return lim;
   endfunction

endpackage

FILE: rtl/cascadable_four_channel_timer.sv
// channel   direction  payload       handshake
// req_      in         tmr_req_type  req_valid / req_stall
// rsp_      out        tmr_rsp_type  rsp_valid / rsp_stall
//
// One request word is taken per cycle while req_stall is low; its response is registered and valid in the next cycle.
// Overflow carries ripple through the row of timer cells within that cycle.
// Synchronous reset clears all timers and empties the response register.
// Requests stall only while a held response is itself stalled.
module cascadable_four_channel_timer
   import tmr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  tmr_req_type req_word,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output tmr_rsp_type rsp_word
);

   logic        rsp_valid_ff, rsp_valid_in;
   tmr_rsp_type rsp_word_ff, rsp_word_in;

   logic        accept;
   tmr_cmd_type cmd;
   logic [NUM_CHANNELS-1:0] sel;
   logic [NUM_CHANNELS-1:0] carry;
   tmr_stat_type            stat [NUM_CHANNELS];
   logic [IRQ_W-1:0]        irq_bits;
   logic [DMA_W-1:0]        dma_bits;
   logic [COUNT_W-1:0]      count_sel;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   // decode the request word into a cell command
   always_comb begin
      cmd.tick         = accept && (req_word.func == FUNC_TICK);
      cmd.ctl_wr       = accept && (req_word.func == FUNC_CTRL);
      cmd.rld_wr       = accept && (req_word.func == FUNC_RELOAD);
      cmd.start        = req_word.start_req;
      cmd.irq_en       = req_word.int_enable;
      cmd.cascade      = req_word.cascade;
      cmd.prescale_sel = req_word.prescale_sel;
      cmd.reload_value = req_word.reload_value;
   end

   // the first cell has no predecessor
   assign carry[0] = 1'b0;

   // row of timer cells
   for (genvar t = 0; t < NUM_CHANNELS; t++) begin : g_cell
      assign sel[t] = (32'(req_word.timer_id) == t);
      tmr_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .cmd      (cmd),
         .select   (sel[t]),
         .carry_in (carry[t]),
         .stat     (stat[t])
      );
      // the last cell's overflow feeds no neighbor
      if (t < NUM_CHANNELS - 1) begin : g_carry
         assign carry[t+1] = stat[t].overflow;
      end
   end

   // pulse vectors and selected counter
   always_comb begin
      irq_bits  = '0;
      dma_bits  = '0;
      count_sel = '0;
      for (int t = 0; t < NUM_CHANNELS; t++) begin
         if (t < IRQ_W) begin
            irq_bits[t[1:0]] = stat[t].irq;
         end
         if (t < DMA_W) begin
            dma_bits[t[0]] = stat[t].overflow;
         end
         if (sel[t]) begin
            count_sel = stat[t].count;
         end
      end
   end

   // response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (accept) begin
         rsp_valid_in              = 1'b1;
         rsp_word_in.irq_pulse     = irq_bits;
         rsp_word_in.dma_request   = dma_bits;
         rsp_word_in.counter_value = count_sel;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

FILE: rtl/tmr_cell.sv
module tmr_cell
   import tmr_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  tmr_cmd_type  cmd,
   input  logic         select,
   input  logic         carry_in,
   output tmr_stat_type stat
);

   logic [COUNT_W-1:0] count_ff, count_in;
   logic [COUNT_W-1:0] reload_ff, reload_in;
   logic [PRESC_W-1:0] presc_ff, presc_in;
   logic               running_ff, running_in;
   logic               irq_on_ff, irq_on_in;
   logic               cascade_ff, cascade_in;
   logic [1:0]         mode_ff, mode_in;

   logic presc_run, presc_hit, step, ovf;

   // step decision: prescaler or overflow of the previous cell
   always_comb begin
      presc_run = cmd.tick && running_ff && !cascade_ff;
      presc_hit = presc_ff >= presc_limit(mode_ff);
      step      = cmd.tick && running_ff && (cascade_ff ? carry_in : presc_hit);
      ovf       = step && (count_ff >= COUNT_MAX);
   end

   // next state
   always_comb begin
      count_in   = count_ff;
      reload_in  = reload_ff;
      presc_in   = presc_ff;
      running_in = running_ff;
      irq_on_in  = irq_on_ff;
      cascade_in = cascade_ff;
      mode_in    = mode_ff;
      if (presc_run) begin
         presc_in = presc_hit ? '0 : presc_ff + PRESC_W'(1);
      end
      if (step) begin
         count_in = ovf ? reload_ff : count_ff + COUNT_W'(1);
      end
      if (select && cmd.ctl_wr) begin
         running_in = cmd.start;
         irq_on_in  = cmd.irq_en;
         cascade_in = cmd.cascade;
         mode_in    = cmd.prescale_sel;
         if (cmd.start) begin
            if (!running_ff) begin
               count_in = reload_ff;
            end
            presc_in = '0;
         end
      end
      if (select && cmd.rld_wr) begin
         reload_in = cmd.reload_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         reload_ff  <= '0;
         presc_ff   <= '0;
         running_ff <= 1'b0;
         irq_on_ff  <= 1'b0;
         cascade_ff <= 1'b0;
         mode_ff    <= '0;
      end else begin
         count_ff   <= count_in;
         reload_ff  <= reload_in;
         presc_ff   <= presc_in;
         running_ff <= running_in;
         irq_on_ff  <= irq_on_in;
         cascade_ff <= cascade_in;
         mode_ff    <= mode_in;
      end
   end

   // report count after this word
   always_comb begin
      stat.overflow = ovf;
      stat.irq      = ovf && irq_on_ff;
      stat.count    = count_in;
   end

endmodule

FILE: rtl/tmr_checker.sv
module tmr_checker
   import tmr_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input tmr_req_type req_word,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input tmr_rsp_type rsp_word
);

   // empty after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // every accepted word yields a response
   a_accept_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> rsp_valid)
      else $error("accepted word produced no response");

   // writes never pulse
   a_write_quiet: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_word.func != FUNC_TICK
      |=> rsp_word.irq_pulse == '0 && rsp_word.dma_request == '0)
      else $error("pulse on a non-tick word");

   // input stalls only behind a stalled response
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled without output back-pressure");

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
      else $error("stalled response changed");

endmodule

bind cascadable_four_channel_timer tmr_checker u_tmr_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_word  (req_word),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_word  (rsp_word)
);

FILE: verif/cascadable_four_channel_timer_test.sv
module cascadable_four_channel_timer_test;
   import tmr_pkg::*;

   // function code the block leaves unused
   localparam logic [1:0] FUNC_UNUSED = 2'd3;

   localparam int unsigned RANDOM_WORDS  = 1925;
   localparam int unsigned LONG_HOLD_AT  = 700;
   localparam int unsigned LONG_HOLD_LEN = 80;
   localparam int unsigned DRAIN_CYCLES  = 4;
   localparam int unsigned RUN_LIMIT     = 2000000;

   // log2 of each prescaler ratio, indexed by prescale_sel
   localparam int unsigned DIV_SHIFT [4] = '{0, 6, 8, 10};

   typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_BEAT} stall_mode_type;

   typedef struct {
      tmr_req_type w;
      bit          typed;
      tmr_rsp_type r;
   } plan_row_type;

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   tmr_req_type req_word  = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   tmr_rsp_type rsp_word;

   // timer state as the block should hold it
   logic [COUNT_W-1:0] timer_count  [NUM_CHANNELS] = '{default: '0};
   logic [COUNT_W-1:0] timer_reload [NUM_CHANNELS] = '{default: '0};
   logic [PRESC_W-1:0] timer_presc  [NUM_CHANNELS] = '{default: '0};
   logic [1:0]         timer_psel   [NUM_CHANNELS] = '{default: '0};
   bit                 timer_run    [NUM_CHANNELS] = '{default: 1'b0};
   bit                 timer_irq_en [NUM_CHANNELS] = '{default: 1'b0};
   bit                 timer_casc   [NUM_CHANNELS] = '{default: 1'b0};

   tmr_rsp_type  pending_rsp [$];
   tmr_req_type  setup_q [$];
   plan_row_type plan [$];

   int unsigned mismatches = 0;
   int unsigned rsp_seen   = 0;
   int unsigned words_sent = 0;
   int unsigned wrap_total = 0;
   int unsigned rx_cycle   = 0;
   int unsigned hold_left  = 0;
   bit          hold_done  = 1'b0;

   cascadable_four_channel_timer u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   always #2 clock = ~clock;

   // run one request word through the timer row, return the response it causes
   function automatic tmr_rsp_type advance_timers(input tmr_req_type w);
      tmr_rsp_type        r;
      logic [PRESC_W-1:0] lim;
      int unsigned        t;
      int unsigned        id;
      bit                 carry;
      bit                 bump;
      bit                 wrap;
      bit                 was_running;
      r = '0;
      id = w.timer_id;
      if (w.func == FUNC_TICK) begin
         carry = 1'b0;
         for (t = 0; t < NUM_CHANNELS; t++) begin
            bump = 1'b0;
            wrap = 1'b0;
            if (timer_run[t]) begin
               if (timer_casc[t]) begin
                  // cascade step only from an overflow of the timer below
                  bump = (t > 0) && carry;
               end else begin
                  lim = PRESC_W'((1 << DIV_SHIFT[timer_psel[t]]) - 1);
                  if (timer_presc[t] >= lim) begin
                     timer_presc[t] = '0;
                     bump = 1'b1;
                  end else begin
                     timer_presc[t] = timer_presc[t] + 1'b1;
                  end
               end
            end
            if (bump) begin
               if (timer_count[t] >= COUNT_MAX) begin
                  timer_count[t] = timer_reload[t];
                  wrap = 1'b1;
               end else begin
                  timer_count[t] = timer_count[t] + 1'b1;
               end
            end
            if (wrap) begin
               wrap_total++;
               if (timer_irq_en[t] && t < IRQ_W) r.irq_pulse[t] = 1'b1;
               if (t < DMA_W) r.dma_request[t] = 1'b1;
            end
            carry = wrap;
         end
      end else if (w.func == FUNC_CTRL) begin
         was_running = timer_run[id];
         timer_run[id] = w.start_req;
         timer_irq_en[id] = w.int_enable;
         timer_casc[id] = w.cascade;
         timer_psel[id] = w.prescale_sel;
         // start from stopped loads the counter, any running write clears the prescaler
         if (w.start_req) begin
            if (!was_running) timer_count[id] = timer_reload[id];
            timer_presc[id] = '0;
         end
      end else if (w.func == FUNC_RELOAD) begin
         timer_reload[id] = w.reload_value;
      end
      r.counter_value = timer_count[id];
      return r;
   endfunction

   function automatic tmr_req_type mk_req(input int unsigned func, input int unsigned id,
                                          input int unsigned start, input int unsigned irq,
                                          input int unsigned casc, input int unsigned psel,
                                          input int unsigned reload);
      tmr_req_type w;
      w.func         = 2'(func);
      w.timer_id     = 2'(id);
      w.start_req    = 1'(start);
      w.int_enable   = 1'(irq);
      w.cascade      = 1'(casc);
      w.prescale_sel = 2'(psel);
      w.reload_value = 16'(reload);
      return w;
   endfunction

   function automatic tmr_rsp_type mk_rsp(input int unsigned irq, input int unsigned dma,
                                          input int unsigned cnt);
      tmr_rsp_type r;
      r.irq_pulse     = IRQ_W'(irq);
      r.dma_request   = DMA_W'(dma);
      r.counter_value = COUNT_W'(cnt);
      return r;
   endfunction

   function automatic void plan_add(input tmr_req_type w, input bit typed,
                                    input tmr_rsp_type r);
      plan_row_type row;
      row.w = w;
      row.typed = typed;
      row.r = r;
      plan.push_back(row);
   endfunction

   // mostly divide by one so counters move, the slow ratios now and then
   function automatic logic [1:0] pick_divider();
      int unsigned p;
      p = $urandom_range(0, 19);
      if (p < 12) return PRESC_DIV1;
      if (p < 17) return PRESC_DIV64;
      if (p < 19) return PRESC_DIV256;
      return PRESC_DIV1024;
   endfunction

   // reload values near the top so overflows come often
   function automatic logic [COUNT_W-1:0] pick_reload();
      int unsigned p;
      p = $urandom_range(0, 3);
      if (p < 2) return COUNT_W'(32'hFFFF - $urandom_range(0, 63));
      if (p == 2) return COUNT_W'(32'hFFFF - $urandom_range(0, 1023));
      return COUNT_W'($urandom);
   endfunction

   function automatic tmr_req_type next_random_word();
      tmr_req_type w;
      int unsigned pick;
      if (setup_q.size() != 0) return setup_q.pop_front();
      pick = $urandom_range(0, 99);
      w.func         = FUNC_TICK;
      w.timer_id     = 2'($urandom_range(0, 3));
      w.start_req    = 1'($urandom_range(0, 1));
      w.int_enable   = 1'($urandom_range(0, 1));
      w.cascade      = 1'($urandom_range(0, 1));
      w.prescale_sel = 2'($urandom_range(0, 3));
      w.reload_value = 16'($urandom);
      if (pick < 7) begin
         // program one timer: new reload, stop, then start from stopped
         setup_q.push_back(mk_req(FUNC_CTRL, w.timer_id, 0, $urandom_range(0, 1),
                                  $urandom_range(0, 1), $urandom_range(0, 3), $urandom));
         setup_q.push_back(mk_req(FUNC_CTRL, w.timer_id, 1, $urandom_range(0, 1),
                                  $urandom_range(0, 2) == 0, pick_divider(), $urandom));
         w.func = FUNC_RELOAD;
         w.reload_value = pick_reload();
      end else if (pick < 73) begin
         w.func = FUNC_TICK;
      end else if (pick < 83) begin
         w.func = FUNC_CTRL;
         w.start_req = ($urandom_range(0, 5) != 0);
         w.cascade = ($urandom_range(0, 2) == 0);
         w.prescale_sel = pick_divider();
      end else if (pick < 97) begin
         w.func = FUNC_RELOAD;
         w.reload_value = pick_reload();
      end else begin
         w.func = FUNC_UNUSED;
      end
      return w;
   endfunction

   // offer one word until taken, then queue what it should produce
   task automatic offer(input tmr_req_type w, input bit typed, input tmr_rsp_type typed_rsp);
      tmr_rsp_type predicted;
      req_word  <= w;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = advance_timers(w);
      pending_rsp.push_back(typed ? typed_rsp : predicted);
      words_sent++;
   endtask

   task automatic idle_for(input int unsigned n);
      req_valid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   task automatic wait_for_responses();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_rsp.size() != 0);
   endtask

   // response check and receiver stall pattern
   always @(posedge clock) begin
      tmr_rsp_type    want;
      stall_mode_type mode;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsp.size() == 0) begin
            $error("response word with nothing pending: %h", rsp_word);
            mismatches++;
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_word.irq_pulse !== want.irq_pulse) begin
               $error("irq_pulse expected %h got %h", want.irq_pulse, rsp_word.irq_pulse);
               mismatches++;
            end
            if (rsp_word.dma_request !== want.dma_request) begin
               $error("dma_request expected %h got %h", want.dma_request,
                      rsp_word.dma_request);
               mismatches++;
            end
            if (rsp_word.counter_value !== want.counter_value) begin
               $error("counter_value expected %h got %h", want.counter_value,
                      rsp_word.counter_value);
               mismatches++;
            end
         end
         rsp_seen++;
      end
      rx_cycle++;
      mode = stall_mode_type'((rx_cycle / 600) % 4);
      if (hold_left != 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (rsp_seen >= LONG_HOLD_AT && !hold_done) begin
         // one long hold so the block fills and stalls its input
         hold_done = 1'b1;
         hold_left = LONG_HOLD_LEN - 1;
         rsp_stall <= 1'b1;
      end else begin
         case (mode)
            STALL_NONE:  rsp_stall <= 1'b0;
            STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: rsp_stall <= ($urandom_range(0, 9) < 6);
            default:     rsp_stall <= ((rx_cycle % 5) < 2);
         endcase
      end
   end

   // main sequence
   initial begin
      tmr_req_type w;
      int unsigned sent;
      int unsigned burst;
      int unsigned gap;
      bit          paused_once;
      sent = 0;
      paused_once = 1'b0;

      // nothing runs after reset, unused code does nothing
      plan_add(mk_req(FUNC_TICK, 0, 0, 0, 0, PRESC_DIV1, 0), 1'b1, mk_rsp(0, 0, 0));
      plan_add(mk_req(FUNC_UNUSED, 3, 1, 1, 1, PRESC_DIV1024, 16'hFFFF), 1'b1,
               mk_rsp(0, 0, 0));
      plan_add(mk_req(FUNC_RELOAD, 0, 0, 0, 0, PRESC_DIV1, 16'hFFFF), 1'b1, mk_rsp(0, 0, 0));
      // start timer 0 at the top, overflow on the next tick
      plan_add(mk_req(FUNC_CTRL, 0, 1, 1, 0, PRESC_DIV1, 0), 1'b1, mk_rsp(0, 0, 16'hFFFF));
      plan_add(mk_req(FUNC_TICK, 0, 0, 0, 0, PRESC_DIV1, 0), 1'b1, mk_rsp(1, 1, 16'hFFFF));
      // timer 1 cascades from timer 0 with irq off
      plan_add(mk_req(FUNC_RELOAD, 1, 0, 0, 0, PRESC_DIV1, 16'hFFFE), 1'b1, mk_rsp(0, 0, 0));
      plan_add(mk_req(FUNC_CTRL, 1, 1, 0, 1, PRESC_DIV1024, 0), 1'b1,
               mk_rsp(0, 0, 16'hFFFE));
      plan_add(mk_req(FUNC_TICK, 1, 0, 0, 0, PRESC_DIV1, 0), 1'b1, mk_rsp(1, 1, 16'hFFFF));
      plan_add(mk_req(FUNC_TICK, 1, 0, 0, 0, PRESC_DIV1, 0), 1'b1, mk_rsp(1, 3, 16'hFFFE));
      // cascade into a stopped timer
      plan_add(mk_req(FUNC_CTRL, 2, 0, 1, 1, PRESC_DIV256, 0), 1'b0, '0);
      plan_add(mk_req(FUNC_TICK, 2, 0, 0, 0, PRESC_DIV1, 0), 1'b0, '0);
      // ripple through timers 1, 2 and 3 in one tick
      plan_add(mk_req(FUNC_RELOAD, 2, 1, 1, 1, PRESC_DIV1024, 16'hFFFF), 1'b0, '0);
      plan_add(mk_req(FUNC_CTRL, 2, 1, 1, 1, PRESC_DIV256, 0), 1'b0, '0);
      plan_add(mk_req(FUNC_RELOAD, 3, 0, 0, 0, PRESC_DIV1, 16'h0000), 1'b0, '0);
      plan_add(mk_req(FUNC_CTRL, 3, 1, 1, 1, PRESC_DIV64, 16'hFFFF), 1'b0, '0);
      plan_add(mk_req(FUNC_TICK, 3, 0, 0, 0, PRESC_DIV1, 0), 1'b0, '0);
      plan_add(mk_req(FUNC_TICK, 2, 1, 1, 1, PRESC_DIV1024, 16'hFFFF), 1'b0, '0);
      // timer 0 in cascade mode never counts
      plan_add(mk_req(FUNC_CTRL, 0, 1, 1, 1, PRESC_DIV1, 0), 1'b0, '0);
      plan_add(mk_req(FUNC_TICK, 0, 0, 0, 0, PRESC_DIV1, 0), 1'b0, '0);
      plan_add(mk_req(FUNC_TICK, 0, 0, 0, 0, PRESC_DIV1, 0), 1'b0, '0);
      // stop keeps the count, restart reloads it
      plan_add(mk_req(FUNC_CTRL, 0, 0, 0, 0, PRESC_DIV64, 0), 1'b0, '0);
      plan_add(mk_req(FUNC_CTRL, 0, 1, 0, 0, PRESC_DIV64, 0), 1'b0, '0);
      plan_add(mk_req(FUNC_TICK, 0, 0, 0, 0, PRESC_DIV1, 0), 1'b0, '0);
      plan_add(mk_req(FUNC_CTRL, 3, 0, 0, 0, PRESC_DIV1, 0), 1'b0, '0);
      plan_add(mk_req(FUNC_RELOAD, 3, 0, 0, 0, PRESC_DIV1, 16'h5A5A), 1'b0, '0);

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed table
      foreach (plan[i]) begin
         offer(plan[i].w, plan[i].typed, plan[i].r);
         gap = $urandom_range(0, 2);
         if (gap != 0) idle_for(gap);
      end
      wait_for_responses();

      // random words in bursts, one full pause half way
      while (sent < RANDOM_WORDS) begin
         burst = $urandom_range(1, 40);
         while (burst != 0 && sent < RANDOM_WORDS) begin
            w = next_random_word();
            offer(w, 1'b0, '0);
            if (w.func != FUNC_UNUSED) sent++;
            burst--;
            if (sent == RANDOM_WORDS / 2 && !paused_once) begin
               paused_once = 1'b1;
               wait_for_responses();
            end
         end
         if ((sent / 300) % 3 != 1) idle_for($urandom_range(1, 8));
      end

      wait_for_responses();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d request words sent, %0d response words checked", words_sent, rsp_seen);
      $display("%0d timer overflows seen across ticks, cascades, holds and pauses", wrap_total);
      if (mismatches == 0) begin
         $display("cascadable_four_channel_timer test passed");
      end else begin
         $display("cascadable_four_channel_timer test failed");
      end
      $finish;
   end

   // watchdog
   initial begin
      #(RUN_LIMIT);
      $display("cascadable_four_channel_timer test failed");
      $finish;
   end

endmodule

FILE: files.f
rtl/tmr_pkg.sv
rtl/tmr_cell.sv
rtl/cascadable_four_channel_timer.sv
rtl/tmr_checker.sv
verif/cascadable_four_channel_timer_test.sv
